// File: hw/rtl/acd_pkg.sv
// shared types, constants and character helpers for the ascii can command decoder
`default_nettype none

package acd_pkg;

  localparam int unsigned LINE_BYTES = 40;
  localparam int unsigned LB_AW      = $clog2(LINE_BYTES);
  localparam int unsigned CW         = 8;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_BELL = 8'h07;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_LT   = 8'h74;
  localparam logic [7:0] CH_UT   = 8'h54;
  localparam logic [7:0] CH_LR   = 8'h72;
  localparam logic [7:0] CH_UR   = 8'h52;
  localparam logic [7:0] CH_UM   = 8'h4D;
  localparam logic [7:0] CH_LM   = 8'h6D;
  localparam logic [7:0] CH_LS   = 8'h73;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_V    = 8'h56;
  localparam logic [7:0] CH_Z    = 8'h5A;

  localparam logic CFG_HW_VERSION = 1'b0;
  localparam logic CFG_FW_VERSION = 1'b1;

  typedef enum logic [2:0] {
    K_CHAR,
    K_FRAME,
    K_RATE,
    K_OPEN_N,
    K_OPEN_L,
    K_STAMP
  } kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RATE,
    OP_FRAME,
    OP_OPEN_N,
    OP_OPEN_L,
    OP_STAMP,
    OP_FLAGS,
    OP_SERIAL,
    OP_VERSION
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EVAL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [LB_AW-1:0] idx;
    logic [7:0]       ch;
    logic             ext;
  } acc_cmd_t;

  function automatic logic [3:0] nibble_of(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = {4'h3, v};
    end else begin
      c = 8'h37 + {4'h0, v};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/acd_line_buf.sv
// line store memory with fill count and registered read port
`default_nettype none

module acd_line_buf
  import acd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic             clear_i,
  input  wire logic [7:0]       wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [LB_AW-1:0] rd_addr_i,
  output logic      [7:0]       rd_data_o,
  output logic      [LB_AW-1:0] count_o
);

  logic [7:0]       mem_q [LINE_BYTES];
  logic [7:0]       rd_data_q;
  logic [LB_AW-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (push_i) begin
      if (count_q == LB_AW'(LINE_BYTES - 1)) begin
        count_d = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[count_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/acd_field_acc.sv
// shared nibble shift unit that gathers identifier and data digits
`default_nettype none

module acd_field_acc
  import acd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire acc_cmd_t cmd_i,
  output logic [31:0]   id_o,
  output logic [63:0]   data_o
);

  logic [31:0]   id_q;
  logic [63:0]   data_q;
  logic [CW-1:0] idx_w, dp_w, k_w;
  logic [3:0]    nib_w;

  always_comb begin
    idx_w = CW'(cmd_i.idx);
    dp_w  = cmd_i.ext ? 8'd9 : 8'd4;
    k_w   = idx_w - dp_w - 8'd1;
    nib_w = nibble_of(cmd_i.ch);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      id_q   <= '0;
      data_q <= '0;
    end else if (cmd_i.valid) begin
      if (idx_w >= 8'd1 && idx_w < dp_w) begin
        id_q <= {id_q[27:0], nib_w};
      end else if (idx_w > dp_w && k_w < 8'd16) begin
        data_q[{4'd15 - k_w[3:0], 2'b00} +: 4] <= nib_w;
      end
    end
  end

  assign id_o   = id_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// File: hw/rtl/ascii_can_command_decoder_core.sv
// ascii can command decoder top: line gathering, command sequencer, result register
// an ordinary character is stored and the next one can be taken every clock while idle
// a carriage return ending a line starts the store walk
// (one memory read a cycle through the nibble unit, then the read pipeline drains), a
// decode step, then one result a cycle (up to six) while the output register is free
// reset (async, active low) clears count, channel flags, sequencer; versions reset to 0x10
`default_nettype none

module ascii_can_command_decoder_core
  import acd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_char_i,
  input  wire logic        tx_full_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [2:0]  kind_o,
  output logic      [7:0]  out_char_o,
  output logic      [31:0] frame_id_o,
  output logic             frame_extended_o,
  output logic             frame_remote_o,
  output logic      [3:0]  frame_length_o,
  output logic      [63:0] frame_data_o,
  output logic      [2:0]  rate_index_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  state_e           state_q, state_d;
  logic [LB_AW-1:0] len_q, ptr_q, pidx_q, count_w;
  logic             tx_q, pv_q, open_q, rate_q;
  logic [7:0]       cmd_q, c1_q, dlc_ch_q, rd_data_w;
  logic [7:0]       hw_q, fw_q;
  op_e              op_q, op_w;
  logic             ok_q, ok_w;
  logic [2:0]       seq_q;
  logic [2:0]       rate_idx_q;
  logic [3:0]       dlc_q;
  logic             ext_q, rtr_q;

  logic             in_fire_w, start_w, push_w, issue_w, load_w;
  logic             ext_w, rtr_w, frame_ok_w;
  logic [CW-1:0]    len_w, d_w, dlc_w, dp_w;
  logic [31:0]      id_w;
  logic [63:0]      data_w;
  acc_cmd_t         acc_cmd_w;

  kind_e            r_kind;
  logic [7:0]       r_char;
  logic             r_last;

  logic             out_valid_q;
  kind_e            kind_q;
  logic [7:0]       char_q;
  logic [31:0]      id_q;
  logic             oext_q, ortr_q, last_q;
  logic [3:0]       olen_q;
  logic [63:0]      odata_q;
  logic [2:0]       orate_q;

  acd_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_w),
    .clear_i   (start_w),
    .wr_data_i (rx_char_i),
    .rd_en_i   (issue_w),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data_w),
    .count_o   (count_w)
  );

  acd_field_acc u_field_acc (
    .clk_i  (clk_i),
    .cmd_i  (acc_cmd_w),
    .id_o   (id_w),
    .data_o (data_w)
  );

  // command decode on gathered fields
  always_comb begin
    ext_w = (cmd_q == CH_UT) || (cmd_q == CH_UR);
    rtr_w = (cmd_q == CH_LR) || (cmd_q == CH_UR);
    len_w = CW'(len_q);
    d_w   = c1_q - CH_ZERO;
    dlc_w = dlc_ch_q - CH_ZERO;
    dp_w  = ext_w ? 8'd9 : 8'd4;
    frame_ok_w = open_q && (len_w >= dp_w + 8'd1) && (dlc_w <= 8'd8) &&
                 (rtr_w ? (len_w == dp_w + 8'd1)
                        : (len_w == {dlc_w[6:0], 1'b0} + dp_w + 8'd1)) &&
                 !tx_q;
    op_w = OP_NONE;
    ok_w = 1'b1;
    unique case (cmd_q)
      CH_S: begin
        if (len_w == 8'd2 && !open_q && d_w <= 8'd8 && d_w != 8'd7) begin
          op_w = OP_RATE;
        end else begin
          ok_w = 1'b0;
        end
      end
      CH_LT, CH_UT, CH_LR, CH_UR: begin
        if (frame_ok_w) begin
          op_w = OP_FRAME;
        end else begin
          ok_w = 1'b0;
        end
      end
      CH_UM, CH_LM, CH_LS: begin
        ok_w = 1'b0;
      end
      CH_O, CH_L: begin
        if (!open_q && rate_q) begin
          op_w = (cmd_q == CH_O) ? OP_OPEN_N : OP_OPEN_L;
        end else begin
          ok_w = 1'b0;
        end
      end
      CH_C: begin
        ok_w = open_q;
      end
      CH_F: begin
        op_w = OP_FLAGS;
      end
      CH_N: begin
        op_w = OP_SERIAL;
      end
      CH_V: begin
        op_w = OP_VERSION;
      end
      CH_Z: begin
        if (!open_q && len_w == 8'd2) begin
          op_w = OP_STAMP;
        end else begin
          ok_w = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result of the current sequence step
  always_comb begin
    r_kind = K_CHAR;
    r_char = ok_q ? CH_CR : CH_BELL;
    r_last = 1'b1;
    unique case (op_q)
      OP_RATE, OP_FRAME, OP_OPEN_N, OP_OPEN_L, OP_STAMP: begin
        if (seq_q == 3'd0) begin
          r_last = 1'b0;
          unique case (op_q)
            OP_RATE:   r_kind = K_RATE;
            OP_FRAME:  r_kind = K_FRAME;
            OP_OPEN_N: r_kind = K_OPEN_N;
            OP_OPEN_L: r_kind = K_OPEN_L;
            default:   r_kind = K_STAMP;
          endcase
        end
      end
      OP_FLAGS: begin
        if (seq_q < 3'd2) begin
          r_last = 1'b0;
          r_char = CH_ZERO;
        end
      end
      OP_SERIAL: begin
        if (seq_q == 3'd0) begin
          r_last = 1'b0;
          r_char = CH_N;
        end else if (seq_q < 3'd5) begin
          r_last = 1'b0;
          r_char = CH_ZERO;
        end
      end
      OP_VERSION: begin
        r_last = (seq_q >= 3'd5);
        unique case (seq_q)
          3'd0:    r_char = CH_V;
          3'd1:    r_char = hex_char(hw_q[7:4]);
          3'd2:    r_char = hex_char(hw_q[3:0]);
          3'd3:    r_char = hex_char(fw_q[7:4]);
          3'd4:    r_char = hex_char(fw_q[3:0]);
          default: r_char = CH_CR;
        endcase
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_w) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!issue_w && !pv_q) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_w && r_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_fire_w  = in_valid_i && !in_stall_o;
    push_w     = in_fire_w && (rx_char_i != CH_CR);
    start_w    = in_fire_w && (rx_char_i == CH_CR) && (count_w != '0);
    issue_w    = (state_q == ST_WALK) && (ptr_q < len_q);
    load_w     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
    acc_cmd_w.clear = start_w;
    acc_cmd_w.valid = pv_q;
    acc_cmd_w.idx   = pidx_q;
    acc_cmd_w.ch    = rd_data_w;
    acc_cmd_w.ext   = ext_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pv_q        <= 1'b0;
      ptr_q       <= '0;
      seq_q       <= '0;
      open_q      <= 1'b0;
      rate_q      <= 1'b0;
      out_valid_q <= 1'b0;
      hw_q        <= 8'h10;
      fw_q        <= 8'h10;
    end else begin
      state_q <= state_d;
      pv_q    <= issue_w;
      if (start_w) begin
        ptr_q <= '0;
      end else if (issue_w) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (state_q == ST_EVAL) begin
        seq_q <= '0;
        if (op_w == OP_RATE) begin
          rate_q <= 1'b1;
        end
        if (op_w == OP_OPEN_N || op_w == OP_OPEN_L) begin
          open_q <= 1'b1;
        end
        if (cmd_q == CH_C && open_q) begin
          open_q <= 1'b0;
        end
      end else if (load_w) begin
        seq_q <= seq_q + 1'b1;
      end
      if (load_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_HW_VERSION) begin
          hw_q <= cfg_data_i;
        end else begin
          fw_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_w) begin
      len_q <= count_w;
      tx_q  <= tx_full_i;
    end
    pidx_q <= ptr_q;
    if (pv_q) begin
      if (pidx_q == '0) begin
        cmd_q <= rd_data_w;
      end
      if (pidx_q == LB_AW'(1)) begin
        c1_q <= rd_data_w;
      end
      if (CW'(pidx_q) == dp_w) begin
        dlc_ch_q <= rd_data_w;
      end
    end
    if (state_q == ST_EVAL) begin
      op_q       <= op_w;
      ok_q       <= ok_w;
      rate_idx_q <= (d_w == 8'd8) ? 3'd7 : d_w[2:0];
      dlc_q      <= dlc_w[3:0];
      ext_q      <= ext_w;
      rtr_q      <= rtr_w;
    end
    if (load_w) begin
      kind_q  <= r_kind;
      char_q  <= (r_kind == K_CHAR) ? r_char : 8'h00;
      id_q    <= (r_kind == K_FRAME) ? id_w : 32'h0;
      oext_q  <= (r_kind == K_FRAME) && ext_q;
      ortr_q  <= (r_kind == K_FRAME) && rtr_q;
      olen_q  <= (r_kind == K_FRAME) ? dlc_q : 4'h0;
      odata_q <= (r_kind == K_FRAME && !rtr_q) ? data_w : 64'h0;
      orate_q <= (r_kind == K_RATE) ? rate_idx_q : 3'h0;
      last_q  <= r_last;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign out_char_o       = char_q;
  assign frame_id_o       = id_q;
  assign frame_extended_o = oext_q;
  assign frame_remote_o   = ortr_q;
  assign frame_length_o   = olen_q;
  assign frame_data_o     = odata_q;
  assign rate_index_o     = orate_q;
  assign last_o           = last_q;

`ifndef SYNTHESIS
  a_walk_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (ptr_q <= len_q))
    else $error("walk pointer beyond line length");

  a_line_end_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_w |=> (state_q == ST_WALK))
    else $error("line end did not start the store walk");

  a_frame_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && kind_q == K_FRAME) |-> open_q)
    else $error("frame sent while channel closed");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_w && r_last) |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("final result did not close the sequence");
`endif

endmodule

`default_nettype wire
